// File: rtl/core/crcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Catmull-Rom curve sampler package
// Request and response types, command and status codes, and the fixed
// arithmetic widths shared by the curve sampler.
// ----------------------------------------------------------------------------
package crcs_pkg;

   localparam int COORD_W  = 32;
   localparam int PARAM_W  = 17;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EVAL   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Fixed-point widths: the fraction s is Q16, the basis polynomials are
   // formed in Q48, the weights are rounded to Q16.
   localparam int FRAC_W = 16;
   localparam int POLY_W = 54;
   localparam int WGT_W  = 20;
   localparam int PROD_W = WGT_W + COORD_W;
   localparam int ACC_W  = 56;
   localparam int RND_W  = ACC_W - 17;

   localparam logic signed [POLY_W-1:0] TWO_Q48   = POLY_W'(2) << 48;
   localparam logic signed [POLY_W-1:0] HALF_Q32  = POLY_W'(1) << 31;
   localparam logic signed [ACC_W-1:0]  HALF_Q17  = ACC_W'(1) << 16;
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef struct packed {
      logic [CMD_W-1:0]          cmd;
      logic signed [COORD_W-1:0] node_x;
      logic signed [COORD_W-1:0] node_y;
      logic signed [COORD_W-1:0] node_z;
      logic [PARAM_W-1:0]        curve_param;
   } crcs_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic [STATUS_W-1:0]       status;
   } crcs_rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } crcs_node_type;

endpackage
`default_nettype wire

// File: rtl/core/catmull_rom_curve_sampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Catmull-Rom curve sampler
// Keeps a table of 3D control nodes in one synchronous memory and evaluates
// the uniform Catmull-Rom curve through them in Q16.16 fixed point.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | crcs_req_type
//   rsp     | out       | rsp_valid / rsp_stall | crcs_rsp_type
//
// One request is worked on at a time. Clear, append and no-op pass through
// the done state only. Evaluate scales, clamps and forms s^2, s^3 and the basis
// weights, then does four node reads from the single memory port, each feeding
// three products through one shared multiplier, then a drain step and rounding.
// A stalled response holds the sequencer in its final state; the next request
// is taken as soon as the result sits in the output register.
// Reset clears the node count; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module catmull_rom_curve_sampler
   import crcs_pkg::*;
#(
   parameter int MAX_NODES       = 16,
   parameter int PARAM_FRAC_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_stall,
   input  wire crcs_req_type req_data,
   output      logic         rsp_valid,
   input  wire logic         rsp_stall,
   output      crcs_rsp_type rsp_data
);

   localparam int CW   = $clog2(MAX_NODES + 1);
   localparam int AW   = $clog2(MAX_NODES);
   localparam int IPW  = CW + 2;
   localparam int FMAX = (PARAM_FRAC_BITS > PARAM_W) ? PARAM_FRAC_BITS : PARAM_W;
   localparam int TSW  = CW + FMAX + 2;
   localparam logic signed [TSW-1:0] TS_LO = TSW'(5) << PARAM_FRAC_BITS;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCALE = 4'd1;
   localparam logic [3:0] S_CLAMP = 4'd2;
   localparam logic [3:0] S_SQ    = 4'd3;
   localparam logic [3:0] S_CUBE  = 4'd4;
   localparam logic [3:0] S_WGT   = 4'd5;
   localparam logic [3:0] S_READ  = 4'd6;
   localparam logic [3:0] S_MUL   = 4'd7;
   localparam logic [3:0] S_DRAIN = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   function automatic logic signed [COORD_W-1:0] round_sat(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [ACC_W-1:0] rsum;
      logic signed [RND_W-1:0] r;
      logic [RND_W-COORD_W:0]  top;
      rsum = acc + HALF_Q17;
      r    = RND_W'(rsum >>> 17);
      top  = r[RND_W-1:COORD_W-1];
      if ((&top) || (~|top)) begin
         return r[COORD_W-1:0];
      end else if (r[RND_W-1]) begin
         return COORD_MIN;
      end else begin
         return COORD_MAX;
      end
   endfunction

   // Control registers
   logic [3:0]              state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [1:0]              k_ff, k_in;
   logic [1:0]              c_ff, c_in;
   logic                    acc_en_ff, acc_en_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic [PARAM_W-1:0]      param_ff, param_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic                    ok_ff, ok_in;
   logic signed [TSW-1:0]   ts_ff, ts_in;
   logic signed [IPW-1:0]   ip_ff, ip_in;
   logic [FRAC_W-1:0]       s_ff, s_in;
   logic [2*FRAC_W-1:0]     s2_ff, s2_in;
   logic [3*FRAC_W-1:0]     s3_ff, s3_in;
   logic signed [WGT_W-1:0] w_ff [4];
   logic signed [WGT_W-1:0] w_in [4];
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [1:0]              acc_sel_ff, acc_sel_in;
   logic signed [ACC_W-1:0] acc_ff [3];
   logic signed [ACC_W-1:0] acc_in [3];
   crcs_rsp_type            rsp_data_ff, rsp_data_in;
   crcs_node_type           mem_rd_ff;

   // Node memory
   crcs_node_type           node_mem [MAX_NODES];
   logic                    mem_we;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   crcs_node_type           wr_word;

   // Combinational helpers
   logic [CW+PARAM_W-1:0]   scaled;
   logic signed [CW:0]      nm5;
   logic signed [TSW-1:0]   ts_hi;
   logic signed [TSW-1:0]   ts_c1;
   logic signed [TSW-1:0]   ts_c;
   logic [PARAM_FRAC_BITS-1:0] frac;
   logic signed [POLY_W-1:0] s1e, s2e, s3e, s1q, s2q;
   logic signed [POLY_W-1:0] f_wgt [4];
   logic [1:0]              rd_k;
   logic signed [IPW:0]     idx_raw;
   logic signed [IPW:0]     n_last;
   logic signed [IPW:0]     idx_cl;
   logic signed [COORD_W-1:0] coord;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign wr_word.x = req_data.node_x;
   assign wr_word.y = req_data.node_y;
   assign wr_word.z = req_data.node_z;

   // Scaling, clamping and basis polynomials
   always_comb begin
      scaled = (CW + PARAM_W)'(count_ff) * (CW + PARAM_W)'(param_ff);
      nm5    = $signed({1'b0, count_ff}) - $signed((CW + 1)'(5));
      ts_hi  = $signed({{(TSW-CW-1){nm5[CW]}}, nm5}) <<< PARAM_FRAC_BITS;
      ts_c1  = (ts_ff < TS_LO) ? TS_LO : ts_ff;
      ts_c   = (ts_c1 > ts_hi) ? ts_hi : ts_c1;
      // A negative clamped value is a whole number, so its fraction is zero.
      frac   = ts_c[PARAM_FRAC_BITS-1:0];

      s1e = $signed({{(POLY_W-FRAC_W){1'b0}}, s_ff});
      s2e = $signed({{(POLY_W-2*FRAC_W){1'b0}}, s2_ff});
      s3e = $signed({{(POLY_W-3*FRAC_W){1'b0}}, s3_ff});
      s1q = s1e <<< 32;
      s2q = s2e <<< 16;
      f_wgt[0] = s2q + s2q - s3e - s1q;
      f_wgt[1] = s3e + (s3e <<< 1) - s2q - (s2q <<< 2) + TWO_Q48;
      f_wgt[2] = (s2q <<< 2) + s1q - s3e - (s3e <<< 1);
      f_wgt[3] = s3e - s2q;
   end

   // Read address: node index ip-1+k clamped into the table
   always_comb begin
      idx_raw = $signed({ip_ff[IPW-1], ip_ff}) + $signed({{(IPW-1){1'b0}}, rd_k})
                - $signed((IPW + 1)'(1));
      n_last  = $signed({3'b000, count_ff}) - $signed((IPW + 1)'(1));
      if (idx_raw[IPW]) begin
         idx_cl = '0;
      end else if (idx_raw > n_last) begin
         idx_cl = n_last;
      end else begin
         idx_cl = idx_raw;
      end
      rd_addr = idx_cl[AW-1:0];
   end

   always_comb begin
      case (c_ff)
         2'd0:    coord = mem_rd_ff.x;
         2'd1:    coord = mem_rd_ff.y;
         default: coord = mem_rd_ff.z;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      c_in         = c_ff;
      acc_en_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      param_in     = param_ff;
      status_in    = status_ff;
      ok_in        = ok_ff;
      ts_in        = ts_ff;
      ip_in        = ip_ff;
      s_in         = s_ff;
      s2_in        = s2_ff;
      s3_in        = s3_ff;
      w_in         = w_ff;
      prod_in      = prod_ff;
      acc_sel_in   = acc_sel_ff;
      acc_in       = acc_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      rd_k         = 2'd0;

      if (acc_en_ff) begin
         acc_in[acc_sel_ff] = acc_ff[acc_sel_ff]
                              + $signed({{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff});
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               param_in  = req_data.curve_param;
               status_in = ST_OK;
               ok_in     = 1'b0;
               state_in  = S_DONE;
               case (req_data.cmd)
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  CMD_APPEND: begin
                     if (count_ff < CW'(MAX_NODES)) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end else begin
                        status_in = ST_FULL;
                     end
                  end
                  CMD_EVAL: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        ok_in     = 1'b1;
                        acc_in[0] = '0;
                        acc_in[1] = '0;
                        acc_in[2] = '0;
                        state_in  = S_SCALE;
                     end
                  end
                  default: begin
                     // No operation: zero result with ok status.
                  end
               endcase
            end
         end
         S_SCALE: begin
            ts_in    = $signed({{(TSW-CW-PARAM_W){1'b0}}, scaled});
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            ip_in    = IPW'(ts_c >>> PARAM_FRAC_BITS);
            s_in     = FRAC_W'({frac, {FRAC_W{1'b0}}} >> PARAM_FRAC_BITS);
            state_in = S_SQ;
         end
         S_SQ: begin
            s2_in    = (2*FRAC_W)'(s_ff) * (2*FRAC_W)'(s_ff);
            state_in = S_CUBE;
         end
         S_CUBE: begin
            s3_in    = (3*FRAC_W)'(s2_ff) * (3*FRAC_W)'(s_ff);
            state_in = S_WGT;
         end
         S_WGT: begin
            for (int i = 0; i < 4; i++) begin
               w_in[i] = WGT_W'((f_wgt[i] + HALF_Q32) >>> 32);
            end
            state_in = S_READ;
         end
         S_READ: begin
            rd_en    = 1'b1;
            rd_k     = 2'd0;
            k_in     = 2'd0;
            c_in     = 2'd0;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in    = PROD_W'(w_ff[k_ff]) * PROD_W'(coord);
            acc_en_in  = 1'b1;
            acc_sel_in = c_ff;
            if (c_ff == 2'd2) begin
               c_in = 2'd0;
               if (k_ff == 2'd3) begin
                  state_in = S_DRAIN;
               end else begin
                  // The next node arrives just after its last coordinate is used.
                  rd_en = 1'b1;
                  rd_k  = k_ff + 2'd1;
                  k_in  = k_ff + 2'd1;
               end
            end else begin
               c_in = c_ff + 2'd1;
            end
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.status  = status_ff;
               rsp_data_in.point_x = ok_ff ? round_sat(acc_ff[0]) : '0;
               rsp_data_in.point_y = ok_ff ? round_sat(acc_ff[1]) : '0;
               rsp_data_in.point_z = ok_ff ? round_sat(acc_ff[2]) : '0;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         k_ff         <= '0;
         c_ff         <= '0;
         acc_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         c_ff         <= c_in;
         acc_en_ff    <= acc_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      param_ff    <= param_in;
      status_ff   <= status_in;
      ok_ff       <= ok_in;
      ts_ff       <= ts_in;
      ip_ff       <= ip_in;
      s_ff        <= s_in;
      s2_ff       <= s2_in;
      s3_ff       <= s3_in;
      w_ff        <= w_in;
      prod_ff     <= prod_in;
      acc_sel_ff  <= acc_sel_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Writes happen only when a request is taken in idle, and reads only
   // while an evaluate runs, so the two never meet on one entry.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[count_ff[AW-1:0]] <= wr_word;
      end
      if (rd_en) begin
         mem_rd_ff <= node_mem[rd_addr];
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_NODES))
      else $error("node count exceeds table size");

   a_read_in_table: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> ({{(CW-AW){1'b0}}, rd_addr} < count_ff))
      else $error("node read outside the written part of the table");

   a_acc_after_mul: assert property (@(posedge clock) disable iff (reset)
      acc_en_ff |-> ($past(state_ff) == S_MUL))
      else $error("accumulate without a preceding multiply");

   a_empty_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_data.cmd == CMD_EVAL && count_ff == '0)
      |=> (state_ff == S_DONE && status_ff == ST_EMPTY))
      else $error("evaluate on empty table not flagged");
`endif

endmodule
`default_nettype wire
